>>> sv/sbl_pkg.sv
// Shared types and constants of the sorted byte list.
// No dependencies; used by every module of the block.
package sbl_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned IDX_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned VAL_W = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W = 7;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_WALK = 4'b0010,
    S_TAIL = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    logic [VAL_W-1:0] wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

endpackage

>>> sv/sbl_ram.sv
// Entry store of the sorted byte list: one write and one read port, registered read.
// Depends on sbl_pkg.
module sbl_ram (
  input  logic                           clk_i,
  input  sbl_pkg::mem_req_t              req_i,
  output logic [sbl_pkg::VAL_W-1:0]      rdata_o
);

  logic [sbl_pkg::VAL_W-1:0] mem [sbl_pkg::CAPACITY];
  logic [sbl_pkg::VAL_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/sbl_ctrl.sv
// Command sequencer of the sorted byte list: walks the entry store, ripples
// entries on insert and delete, and holds the result word. Depends on sbl_pkg.
module sbl_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  output logic                           cmd_ready_o,
  input  logic                           cmd_i,
  input  logic [sbl_pkg::VAL_W-1:0]      value_i,
  output logic                           res_valid_o,
  input  logic                           res_ready_i,
  output logic [sbl_pkg::STATUS_W-1:0]   status_o,
  output logic [sbl_pkg::COUNT_W-1:0]    count_o,
  output sbl_pkg::mem_req_t              req_o,
  input  logic [sbl_pkg::VAL_W-1:0]      rdata_i
);

  localparam logic [sbl_pkg::CNT_W-1:0] CapCnt = sbl_pkg::CNT_W'(sbl_pkg::CAPACITY);

  sbl_pkg::state_e                state_q, state_d;
  logic [sbl_pkg::CNT_W-1:0]      count_q, count_d;
  logic [sbl_pkg::IDX_W-1:0]      idx_q, idx_d;
  logic                           cmd_q, cmd_d;
  logic signed [sbl_pkg::VAL_W-1:0] value_q, value_d;
  logic [sbl_pkg::VAL_W-1:0]      carry_q, carry_d;
  logic                           hit_q, hit_d;
  sbl_pkg::status_e               st_q, st_d;
  logic                           out_valid_q, out_valid_d;
  logic [sbl_pkg::STATUS_W-1:0]   out_status_q, out_status_d;
  logic [sbl_pkg::COUNT_W-1:0]    out_count_q, out_count_d;

  logic                           accept;
  logic                           last;
  logic                           load;
  logic signed [sbl_pkg::VAL_W-1:0] entry;

  assign cmd_ready_o = (state_q == sbl_pkg::S_IDLE);
  assign accept      = cmd_valid_i & cmd_ready_o;
  assign entry       = $signed(rdata_i);
  assign last        = ((sbl_pkg::CNT_W + 1)'(idx_q) ==
                        (sbl_pkg::CNT_W + 1)'(count_q - 1'b1));
  assign load        = (state_q == sbl_pkg::S_FIN) & (~out_valid_q | res_ready_i);

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    idx_d        = idx_q;
    cmd_d        = cmd_q;
    value_d      = value_q;
    carry_d      = carry_q;
    hit_d        = hit_q;
    st_d         = st_q;
    out_valid_d  = out_valid_q & ~res_ready_i;
    out_status_d = out_status_q;
    out_count_d  = out_count_q;
    req_o        = '0;

    case (state_q)
      sbl_pkg::S_IDLE: begin
        if (accept) begin
          cmd_d   = cmd_i;
          value_d = $signed(value_i);
          carry_d = value_i;
          hit_d   = 1'b0;
          idx_d   = '0;
          req_o.re    = 1'b1;
          req_o.raddr = '0;
          if (cmd_i == sbl_pkg::CMD_INSERT) begin
            if (count_q == CapCnt) begin
              st_d    = sbl_pkg::ST_FULL;
              state_d = sbl_pkg::S_FIN;
            end else if (count_q == '0) begin
              state_d = sbl_pkg::S_TAIL;
            end else begin
              state_d = sbl_pkg::S_WALK;
            end
          end else begin
            if (count_q == '0) begin
              st_d    = sbl_pkg::ST_EMPTY;
              state_d = sbl_pkg::S_FIN;
            end else begin
              state_d = sbl_pkg::S_WALK;
            end
          end
        end
      end
      sbl_pkg::S_WALK: begin
        req_o.re    = ~last;
        req_o.raddr = sbl_pkg::IDX_W'(idx_q + 1'b1);
        idx_d       = sbl_pkg::IDX_W'(idx_q + 1'b1);
        if (cmd_q == sbl_pkg::CMD_INSERT) begin
          if (hit_q || !(value_q > entry)) begin
            req_o.we    = 1'b1;
            req_o.waddr = idx_q;
            req_o.wdata = carry_q;
            carry_d     = rdata_i;
            hit_d       = 1'b1;
          end
          if (last) begin
            state_d = sbl_pkg::S_TAIL;
          end
        end else begin
          if (hit_q) begin
            req_o.we    = 1'b1;
            req_o.waddr = sbl_pkg::IDX_W'(idx_q - 1'b1);
            req_o.wdata = rdata_i;
          end else if (entry == value_q) begin
            hit_d = 1'b1;
          end
          if (last) begin
            if (hit_d) begin
              count_d = count_q - 1'b1;
              st_d    = sbl_pkg::ST_DONE;
            end else begin
              st_d    = sbl_pkg::ST_NOT_FOUND;
            end
            state_d = sbl_pkg::S_FIN;
          end
        end
      end
      sbl_pkg::S_TAIL: begin
        req_o.we    = 1'b1;
        req_o.waddr = sbl_pkg::IDX_W'(count_q);
        req_o.wdata = carry_q;
        count_d     = count_q + 1'b1;
        st_d        = sbl_pkg::ST_DONE;
        state_d     = sbl_pkg::S_FIN;
      end
      sbl_pkg::S_FIN: begin
        if (load) begin
          out_valid_d  = 1'b1;
          out_status_d = st_q;
          out_count_d  = sbl_pkg::COUNT_W'(count_q);
          state_d      = sbl_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = sbl_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sbl_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    cmd_q        <= cmd_d;
    value_q      <= value_d;
    carry_q      <= carry_d;
    hit_q        <= hit_d;
    st_q         <= st_d;
    out_status_q <= out_status_d;
    out_count_q  <= out_count_d;
  end

  assign res_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign count_o     = out_count_q;

endmodule

>>> sv/sorted_byte_list.sv
// Sorted byte list top level: bounded ascending multiset of signed bytes.
// An insert or delete walks the entries held before the word, one entry store access per cycle;
// a refused insert or a delete from an empty list goes straight to the result.
// A new word is taken only once the result of the last one is loaded into the result register.
// Reset clears the state, the count and the result valid flag; entries need no clearing.
// Depends on sbl_pkg, sbl_ram and sbl_ctrl.
module sorted_byte_list (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,  // [7:0] value
  input  logic        s_axis_tuser_i,  // [0] cmd
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o   // [1:0] status, [8:2] count, [15:9] zero
);

  sbl_pkg::mem_req_t                mem_req;
  logic [sbl_pkg::VAL_W-1:0]        mem_rdata;
  logic [sbl_pkg::STATUS_W-1:0]     status;
  logic [sbl_pkg::COUNT_W-1:0]      count;

  sbl_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  sbl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid_i),
    .cmd_ready_o (s_axis_tready_o),
    .cmd_i       (s_axis_tuser_i),
    .value_i     (s_axis_tdata_i),
    .res_valid_o (m_axis_tvalid_o),
    .res_ready_i (m_axis_tready_i),
    .status_o    (status),
    .count_o     (count),
    .req_o       (mem_req),
    .rdata_i     (mem_rdata)
  );

  assign m_axis_tdata_o = {7'd0, count, status};

endmodule

>>> verif/sbl_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the sorted byte list: a shadow copy of the sorted store
// predicts status and count per command word. Depends on sbl_pkg.
package sbl_tb_pkg;
  import sbl_pkg::*;

  typedef struct {
    status_e              status;
    logic [COUNT_W-1:0]   count;
  } list_outcome_t;

  class sorted_list_scoreboard;
    logic signed [VAL_W-1:0] shadow_list[$];
    list_outcome_t           awaited_results[$];
    int unsigned             errors = 0;

    function void apply_command(logic cmd, logic [VAL_W-1:0] raw);
      logic signed [VAL_W-1:0] v;
      int unsigned             pos;
      status_e                 st;
      list_outcome_t           outcome;
      v = raw;
      pos = 0;
      if (cmd == CMD_INSERT) begin
        if (shadow_list.size() >= CAPACITY) begin
          st = ST_FULL;
        end else begin
          while (pos < shadow_list.size() && v > shadow_list[pos]) pos++;
          shadow_list.insert(pos, v);
          st = ST_DONE;
        end
      end else if (shadow_list.size() == 0) begin
        st = ST_EMPTY;
      end else begin
        while (pos < shadow_list.size() && shadow_list[pos] != v) pos++;
        if (pos >= shadow_list.size()) begin
          st = ST_NOT_FOUND;
        end else begin
          shadow_list.delete(pos);
          st = ST_DONE;
        end
      end
      outcome.status = st;
      outcome.count  = COUNT_W'(shadow_list.size());
      awaited_results.push_back(outcome);
    endfunction

    function void compare_result(logic [15:0] word);
      list_outcome_t want;
      if (awaited_results.size() == 0) begin
        $error("result word %h with no command pending", word);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      if (word[1:0] !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, word[1:0]);
        errors++;
      end
      if (word[8:2] !== want.count) begin
        $error("count: expected %0d, actual %0d", want.count, word[8:2]);
        errors++;
      end
      if (word[15:9] !== 7'd0) begin
        $error("reserved: expected 0, actual %0h", word[15:9]);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return awaited_results.size();
    endfunction

    function int unsigned held_size();
      return shadow_list.size();
    endfunction

    function logic [VAL_W-1:0] held_at(int unsigned idx);
      return shadow_list[idx];
    endfunction
  endclass

endpackage

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// Top-level testbench for sorted_byte_list: directed and random insert and
// delete words, random sender bursts and receiver stalls. Depends on sbl_pkg, sbl_tb_pkg.
module tb_top;
  import sbl_pkg::*;
  import sbl_tb_pkg::*;

  localparam int unsigned RANDOM_WORDS   = 1030;
  localparam int unsigned HOLDOFF_CYCLES = 600;
  localparam int unsigned HOLDOFF_AT     = 300;
  localparam int unsigned CYCLE_LIMIT    = 1000000;

  typedef enum {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_mode_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;

  sorted_list_scoreboard sb;
  int unsigned           results_seen = 0;
  int unsigned           cycles = 0;

  sorted_byte_list DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always #4 clk_i = ~clk_i;

  task automatic send_word(input logic cmd, input logic [7:0] value);
    @(negedge clk_i);
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= value;
    do @(posedge clk_i); while (!s_tready);
    sb.apply_command(cmd, value);
  endtask

  task automatic idle(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      s_tvalid <= 1'b0;
    end
  endtask

  task automatic run_directed();
    send_word(CMD_DELETE, 8'h05);
    send_word(CMD_INSERT, 8'h00);
    send_word(CMD_DELETE, 8'h00);
    send_word(CMD_INSERT, 8'h7F);
    send_word(CMD_INSERT, 8'h80);
    idle(2);
    send_word(CMD_INSERT, 8'h00);
    send_word(CMD_INSERT, 8'h00);
    send_word(CMD_INSERT, 8'hFF);
    send_word(CMD_INSERT, 8'h01);
    send_word(CMD_DELETE, 8'h00);
    idle(1);
    send_word(CMD_DELETE, 8'h00);
    send_word(CMD_DELETE, 8'h00);
    send_word(CMD_DELETE, 8'h80);
    send_word(CMD_DELETE, 8'h7F);
    send_word(CMD_DELETE, 8'h55);
    send_word(CMD_INSERT, 8'hAA);
    send_word(CMD_DELETE, 8'hFF);
    send_word(CMD_DELETE, 8'h01);
    send_word(CMD_DELETE, 8'hAA);
    send_word(CMD_DELETE, 8'hAA);
  endtask

  task automatic run_random();
    int unsigned sent;
    int          phase_left;
    int unsigned insert_pct;
    bit          narrow;
    logic        cmd;
    logic [7:0]  value;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      phase_left = $urandom_range(20, 120);
      case ($urandom_range(0, 2))
        0:       insert_pct = 90;
        1:       insert_pct = 50;
        default: insert_pct = 15;
      endcase
      narrow = $urandom_range(0, 1);
      while (phase_left > 0 && sent < RANDOM_WORDS) begin
        repeat ($urandom_range(1, 12)) begin
          cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_DELETE;
          if (narrow) value = 8'($urandom_range(0, 8)) - 8'd4;
          else value = 8'($urandom);
          if (cmd == CMD_DELETE && sb.held_size() != 0 && $urandom_range(0, 3) != 0)
            value = sb.held_at($urandom_range(0, sb.held_size() - 1));
          send_word(cmd, value);
          sent++;
          phase_left--;
        end
        if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 6));
      end
    end
  endtask

  // receiver: changing stall patterns plus one long hold-off
  initial begin
    rx_mode_e    mode;
    int unsigned window;
    int unsigned period;
    int unsigned tick;
    bit          holdoff_done;
    m_tready = 1'b0;
    mode = RX_OPEN;
    window = 0;
    period = 2;
    tick = 0;
    holdoff_done = 0;
    forever begin
      @(negedge clk_i);
      if (!holdoff_done && results_seen >= HOLDOFF_AT) begin
        holdoff_done = 1;
        m_tready <= 1'b0;
        repeat (HOLDOFF_CYCLES - 1) @(negedge clk_i);
      end else begin
        if (window == 0) begin
          mode   = rx_mode_e'($urandom_range(0, 2));
          window = $urandom_range(16, 200);
          period = $urandom_range(2, 6);
        end
        window--;
        tick++;
        case (mode)
          RX_OPEN:   m_tready <= 1'b1;
          RX_RANDOM: m_tready <= ($urandom_range(0, 1) == 1);
          default:   m_tready <= (tick % period) != 0;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      sb.compare_result(m_tdata);
      results_seen++;
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("** sorted_byte_list: FAILED **");
    $finish;
  end

  initial begin
    sb = new();
    rst_ni   = 1'b0;
    s_tvalid = 1'b0;
    s_tuser  = CMD_INSERT;
    s_tdata  = 8'h00;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    run_directed();
    run_random();
    idle(1);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (CAPACITY + 8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("** sorted_byte_list: PASSED **");
    end else begin
      $display("** sorted_byte_list: FAILED **");
    end
    $finish;
  end

endmodule
